// File: rtl/core/dfr_pkg.sv
// Package for the decimal fraction reducer: sequencer states, the control
// bundle between sequencer and datapath, and the field widths.
// No dependencies.
package dfr_pkg;

  localparam int unsigned INCH_W = 16;
  localparam int unsigned FRAC_W = 20;

  // Inverse of 5 modulo 2^20, and the largest 20-bit value that is an exact
  // multiple image under that inverse, floor((2^20 - 1) / 5).
  localparam logic [FRAC_W-1:0] INV5      = 20'hCCCCD;
  localparam logic [FRAC_W-1:0] DIV5_MAX  = 20'h33333;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_STEP,
    ST_DONE
  } dfr_state_t;

  typedef struct packed {
    logic idle;    // ready for a new request
    logic load;    // capture the incoming request
    logic step;    // run one reduction step
    logic finish;  // move the result into the output register
  } dfr_ctl_t;

  function automatic longint unsigned pow10(input int unsigned n);
    longint unsigned p;
    p = 64'd1;
    for (int unsigned k = 0; k < n; k++) begin
      p = p * 64'd10;
    end
    return p;
  endfunction

endpackage

// File: rtl/core/dfr_div5.sv
// Shared exact divide-by-five unit of the decimal fraction reducer.
// Depends on dfr_pkg.
module dfr_div5 (
  input  logic [dfr_pkg::FRAC_W-1:0] value,
  output logic [dfr_pkg::FRAC_W-1:0] quotient,
  output logic                       divisible
);

  // Multiplying by the modular inverse of 5 gives value/5 exactly when the
  // division has no remainder; otherwise the product lands above DIV5_MAX.
  // Only the low FRAC_W bits of the product are needed.
  assign quotient  = value * dfr_pkg::INV5;
  assign divisible = (quotient <= dfr_pkg::DIV5_MAX);

endmodule

// File: rtl/core/dfr_fsm.sv
// Sequencer of the decimal fraction reducer: counts the reduction steps and
// hands control to the datapath. Depends on dfr_pkg.
module dfr_fsm #(
  parameter int unsigned DIGITS = 6
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic             out_free,
  output dfr_pkg::dfr_ctl_t ctl
);

  localparam int unsigned CNT_W = $clog2(DIGITS + 1);
  localparam logic [CNT_W-1:0] LAST = CNT_W'(DIGITS - 1);

  dfr_pkg::dfr_state_t state_r, state_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= dfr_pkg::ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    unique case (state_r)
      dfr_pkg::ST_IDLE: begin
        cnt_nxt = '0;
        if (start) begin
          state_nxt = dfr_pkg::ST_STEP;
        end
      end
      dfr_pkg::ST_STEP: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == LAST) begin
          state_nxt = dfr_pkg::ST_DONE;
        end
      end
      dfr_pkg::ST_DONE: begin
        if (out_free) begin
          state_nxt = dfr_pkg::ST_IDLE;
        end
      end
      default: state_nxt = dfr_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    ctl = '0;
    unique case (state_r)
      dfr_pkg::ST_IDLE: begin
        ctl.idle = 1'b1;
        ctl.load = start;
      end
      dfr_pkg::ST_STEP: ctl.step   = 1'b1;
      dfr_pkg::ST_DONE: ctl.finish = out_free;
      default: ctl = '0;
    endcase
  end

endmodule

// File: rtl/core/decimal_fraction_reducer_core.sv
// Decimal fraction reducer. Each request carries whole inches and a fraction
// scaled by 10^DIGITS; the result carries the inches unchanged and the fraction
// in lowest terms, with a zero fraction reported as 0/1 and a fraction at or
// above 10^DIGITS saturated to 10^DIGITS - 1. A request is loaded, makes
// DIGITS passes through the shared divide-by-five and halve step, and is then
// moved into the output register once that register is free. A new request is
// taken while the previous result waits.
// Depends on dfr_pkg, dfr_div5 and dfr_fsm.
module decimal_fraction_reducer_core #(
  parameter int unsigned DIGITS = 6
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // whole_inches[15:0], fraction_digits[35:16], zero pad
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata   // inches_out[15:0], numerator[35:16], denominator[55:36]
);

  localparam int unsigned     FW    = dfr_pkg::FRAC_W;
  localparam longint unsigned SCALE = dfr_pkg::pow10(DIGITS);
  localparam logic [FW-1:0]   SAT   = FW'(SCALE - 64'd1);

  dfr_pkg::dfr_ctl_t ctl;

  logic [dfr_pkg::INCH_W-1:0] inch_r;
  logic [FW-1:0]              num_r, den_r;
  logic [FW-1:0]              frac_in, frac_sat;
  logic [FW-1:0]              q5, num_a, num_nxt, den_a, den_nxt;
  logic                       div5, even;
  logic                       out_valid_r;
  logic [55:0]                out_data_r;

  assign frac_in  = in_tdata[35:16];
  assign frac_sat = ({44'd0, frac_in} >= SCALE) ? SAT : frac_in;

  dfr_fsm #(.DIGITS(DIGITS)) u_fsm (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (in_tvalid),
    .out_free (!out_valid_r || out_tready),
    .ctl      (ctl)
  );

  dfr_div5 u_div5 (
    .value     (num_r),
    .quotient  (q5),
    .divisible (div5)
  );

  // Each step strips at most one factor of 2 and one of 5 from the numerator.
  // A factor that cannot be stripped stays in the denominator instead, so after
  // DIGITS steps den = 2^(DIGITS-a) * 5^(DIGITS-b). Zero divides by both and
  // therefore ends as 0/1.
  assign even    = ~num_r[0];
  assign num_a   = div5 ? q5 : num_r;
  assign num_nxt = even ? (num_a >> 1) : num_a;
  assign den_a   = even ? den_r : (den_r << 1);
  assign den_nxt = div5 ? den_a : (den_a + (den_a << 2));

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      inch_r <= in_tdata[15:0];
      num_r  <= frac_sat;
      den_r  <= FW'(1);
    end else if (ctl.step) begin
      num_r  <= num_nxt;
      den_r  <= den_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctl.finish) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.finish) begin
      out_data_r <= {den_r, num_r, inch_r};
    end
  end

  assign in_tready  = ctl.idle;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

// File: dv/testbench.sv
// Stream testbench for decimal_fraction_reducer_core: directed and random measurements,
// predicted results reduced to lowest terms, and a field-by-field check of each result.
// Depends on dfr_pkg and the reducer RTL.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned FW = dfr_pkg::FRAC_W;
  localparam int unsigned IW = dfr_pkg::INCH_W;

  localparam int unsigned FRAC_DIGITS = 6;
  // Fraction scale, 10^FRAC_DIGITS.
  localparam longint unsigned FRAC_SCALE = dfr_pkg::pow10(FRAC_DIGITS);

  typedef struct packed {
    logic [FW-1:0] frac;
    logic [IW-1:0] inches;
  } measurement_t;

  typedef struct packed {
    logic [FW-1:0] denom;
    logic [FW-1:0] numer;
    logic [IW-1:0] inches;
  } frac_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [39:0] in_tdata = '0;   // whole_inches[15:0], fraction_digits[35:16], zero pad
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [55:0] out_tdata;      // inches_out[15:0], numerator[35:16], denominator[55:36]

  measurement_t measurements_to_send[$];
  frac_result_t expected_fractions[$];
  logic         in_accepted = 1'b0;
  int unsigned  requests_taken = 0;
  int unsigned  results_seen = 0;
  int unsigned  mismatches = 0;

  decimal_fraction_reducer_core #(
    .DIGITS(FRAC_DIGITS)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic frac_result_t reduce_measurement(measurement_t m);
    longint unsigned f;
    longint unsigned a;
    longint unsigned b;
    longint unsigned t;
    frac_result_t r;
    f = m.frac;
    if (f >= FRAC_SCALE) begin
      f = FRAC_SCALE - 1;
    end
    r.inches = m.inches;
    if (f == 0) begin
      r.numer = '0;
      r.denom = 20'd1;
    end else begin
      a = FRAC_SCALE;
      b = f;
      while (b != 0) begin
        t = a % b;
        a = b;
        b = t;
      end
      r.numer = FW'(f / a);
      r.denom = FW'(FRAC_SCALE / a);
    end
    return r;
  endfunction

  task automatic queue_measurement(input int unsigned inches, input int unsigned frac);
    measurement_t m;
    m.inches = IW'(inches);
    m.frac = FW'(frac);
    measurements_to_send.push_back(m);
  endtask

  // Driver: a request stays on the bus until it has been taken.
  always @(negedge clk) begin : request_driver
    logic hold_off;
    hold_off = (requests_taken < 300 || requests_taken >= 420) && $urandom_range(0, 99) < 30;
    if (rst_n && (!in_tvalid || in_accepted)) begin
      if (measurements_to_send.size() != 0 && !hold_off) begin
        in_tdata <= {4'b0, measurements_to_send.pop_front()};
        in_tvalid <= 1'b1;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin : result_stall
    logic stall;
    stall = (results_seen < 300 || results_seen >= 420) && $urandom_range(0, 99) < 30;
    out_tready <= !stall;
  end

  // Monitor: check results first, so a result cannot match a request taken on the same edge.
  always @(posedge clk) begin : monitor
    frac_result_t got;
    frac_result_t want;
    if (!rst_n) begin
      in_accepted <= 1'b0;
    end else begin
      in_accepted <= in_tvalid && in_tready;
      if (out_tvalid && out_tready) begin
        got = out_tdata;
        results_seen <= results_seen + 1;
        if (expected_fractions.size() == 0) begin
          $display("%0t: unexpected result inches=%0d %0d/%0d",
                   $time, got.inches, got.numer, got.denom);
          mismatches <= mismatches + 1;
        end else begin
          want = expected_fractions.pop_front();
          if (got !== want) begin
            if (got.inches !== want.inches)
              $display("%0t: inches expected %0d actual %0d", $time, want.inches, got.inches);
            if (got.numer !== want.numer)
              $display("%0t: numerator expected %0d actual %0d", $time, want.numer, got.numer);
            if (got.denom !== want.denom)
              $display("%0t: denominator expected %0d actual %0d", $time, want.denom, got.denom);
            mismatches <= mismatches + 1;
          end
        end
      end
      if (in_tvalid && in_tready) begin
        expected_fractions.push_back(reduce_measurement(measurement_t'(in_tdata[35:0])));
        requests_taken <= requests_taken + 1;
      end
    end
  end

  initial begin : stimulus
    int unsigned kind;
    int unsigned inches;
    longint unsigned frac;
    // Extremes, zero fraction, saturation, pure powers of two and five, coprime values.
    queue_measurement(0, 0);
    queue_measurement(65535, 0);
    queue_measurement(0, 1);
    queue_measurement(65535, 999999);
    queue_measurement(1, 500000);
    queue_measurement(2, 250000);
    queue_measurement(3, 125000);
    queue_measurement(4, 15625);
    queue_measurement(5, 64);
    queue_measurement(6, 1000000);
    queue_measurement(7, 1048575);
    queue_measurement(8, 524288);
    queue_measurement(9, 3);
    queue_measurement(10, 800000);
    queue_measurement(11, 640000);
    queue_measurement(12, 100000);
    queue_measurement(13, 2);
    queue_measurement(14, 5);
    queue_measurement(15, 333333);
    queue_measurement(16, 524287);
    queue_measurement(32768, 1000001);
    queue_measurement(21845, 43690);
    for (int n = 0; n < 800; n++) begin
      inches = ($urandom_range(0, 9) == 0) ? ($urandom_range(0, 1) * 65535)
                                          : $urandom_range(0, 65535);
      kind = $urandom_range(0, 99);
      if (kind < 55) begin
        frac = $urandom_range(0, 999999);
      end else if (kind < 75) begin
        // Products of small factors give deep reductions.
        frac = $urandom_range(1, 40);
        repeat ($urandom_range(0, 6)) frac = frac * 2;
        repeat ($urandom_range(0, 6)) frac = frac * 5;
        frac = frac % FRAC_SCALE;
      end else if (kind < 85) begin
        frac = $urandom_range(1000000, 1048575);
      end else if (kind < 92) begin
        frac = $urandom_range(0, 100);
      end else begin
        frac = $urandom_range(990000, 999999);
      end
      queue_measurement(inches, int'(frac));
    end

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (measurements_to_send.size() != 0 || in_tvalid) @(negedge clk);
    while (expected_fractions.size() != 0) @(negedge clk);
    repeat (24) @(negedge clk);
    if (mismatches == 0 && expected_fractions.size() == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

  initial begin : watchdog
    #5ms;
    $display("testbench NOT OK");
    $finish;
  end

endmodule
